@@ hdl/spcm_pkg.sv @@
// ----------------------------------------------------------------------------
// spcm_pkg
// Shared widths, codes and control types of the power-cycled moisture sampler.
// ----------------------------------------------------------------------------
package spcm_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned TIME_BITS   = 32;

  localparam int unsigned NOW_BITS  = 32;
  localparam int unsigned ADC_BITS  = 12;
  localparam int unsigned CFG_BITS  = 32;
  localparam int unsigned CFG_ADDR_BITS = 2;
  localparam int unsigned PCT_BITS  = 7;

  // stream words, padded to whole bytes
  localparam int unsigned IN_FIELD_BITS  = NOW_BITS + ADC_BITS;
  localparam int unsigned IN_BITS        = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = 1 + 2 + 1 + PCT_BITS + 1 + 1;
  localparam int unsigned OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // |sample - dry| * 100 fits in SAMPLE_BITS + 7 bits
  localparam int unsigned NUM_BITS = SAMPLE_BITS + PCT_BITS;
  localparam int unsigned CNT_BITS = $clog2(NUM_BITS);

  localparam int unsigned ALU_W0   = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
  localparam int unsigned ALU_BITS = (ALU_W0 > SAMPLE_BITS + 1) ? ALU_W0 : SAMPLE_BITS + 1;

  localparam logic [CFG_BITS-1:0]    INTERVAL_RST = CFG_BITS'(60000);
  localparam logic [CFG_BITS-1:0]    WARMUP_RST   = CFG_BITS'(1000);
  localparam logic [SAMPLE_BITS-1:0] DRY_RST      = SAMPLE_BITS'(3000);
  localparam logic [SAMPLE_BITS-1:0] WET_RST      = SAMPLE_BITS'(1200);
  localparam logic [PCT_BITS-1:0]    PCT_FULL     = PCT_BITS'(100);
  localparam logic [NUM_BITS-1:0]    NUM_FULL     = NUM_BITS'(100);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_INTERVAL = 2'd0,
    REG_WARMUP   = 2'd1,
    REG_DRY      = 2'd2,
    REG_WET      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_OFF     = 2'd0,
    PH_PREPARE = 2'd1,
    PH_MEASURE = 2'd2,
    PH_TURNOFF = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDIFF,
    ST_TCMP,
    ST_NSGN,
    ST_NMAG,
    ST_DSGN,
    ST_DMAG,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } seq_state_e;

  // operand pair fed to the shared subtractor
  typedef enum logic [2:0] {
    OPN_TIME,
    OPN_TCMP,
    OPN_NSGN,
    OPN_NMAG,
    OPN_DSGN,
    OPN_DMAG,
    OPN_DIV
  } opnd_e;

  typedef struct packed {
    logic   in_ready;
    logic   out_load;
    opnd_e  opnd;
    logic   ld_tdiff;
    logic   ld_tcmp;
    logic   ld_nsgn;
    logic   ld_nmag;
    logic   ld_dsgn;
    logic   ld_dmag;
    logic   div_step;
    logic   finish;
  } seq_ctrl_t;

  typedef struct packed {
    logic   in_valid;
    phase_e phase;
    logic   den_zero;
    logic   cnt_last;
    logic   out_free;
  } seq_stat_t;

  function automatic logic [TIME_BITS-1:0] to_time(input logic [NOW_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[TIME_BITS-1:0];
  endfunction

endpackage

@@ hdl/sensor_power_cycle_moisture_sampler.sv @@
// ----------------------------------------------------------------------------
// sensor_power_cycle_moisture_sampler
// Power-cycled soil moisture sampler with dry/wet calibration mapping.
// ----------------------------------------------------------------------------
// Each input word is one poll (time in ms, converter sample); each poll gives
// exactly one output word with the sensor power, phase and the last moisture
// value. One poll is worked through a single shared subtractor under a small
// sequencer, and s_axis_tready is low meanwhile. A poll in the Off or Prepare
// phase takes two subtractor steps for the wrapped time check, a TurnOff poll
// goes straight to the output, and a Measure poll takes four sign/magnitude
// steps, then a restoring division of |sample - dry| * 100 by |wet - dry| at
// one quotient bit per cycle. With equal calibration the division is skipped.
// A finished word waits in the sequencer until the output register has room,
// and the poll is held as long as that register stays full.
// Configuration writes take effect at once.
module sensor_power_cycle_moisture_sampler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spcm_pkg::CFG_ADDR_BITS-1:0]  cfg_addr_i,
  input  logic [spcm_pkg::CFG_BITS-1:0]       cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // now_ms [31:0], adc_sample [43:32]
  input  logic [spcm_pkg::IN_BITS-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sensor_power [0], phase [2:1], sample_taken [3], moisture_percent [10:4],
  // out_of_range [11], calibration_error [12]
  output logic [spcm_pkg::OUT_BITS-1:0]       m_axis_tdata
);

  localparam int unsigned SB = spcm_pkg::SAMPLE_BITS;
  localparam int unsigned TB = spcm_pkg::TIME_BITS;
  localparam int unsigned AB = spcm_pkg::ALU_BITS;
  localparam int unsigned NB = spcm_pkg::NUM_BITS;
  localparam int unsigned CB = spcm_pkg::CNT_BITS;
  localparam int unsigned PB = spcm_pkg::PCT_BITS;

  spcm_pkg::seq_ctrl_t ctrl;
  spcm_pkg::seq_stat_t stat;

  // configuration
  logic [spcm_pkg::CFG_BITS-1:0] interval_q, warmup_q;
  logic [SB-1:0]                 dry_q, wet_q;

  // sequencer state
  spcm_pkg::phase_e phase_q;
  logic             started_q;
  logic [TB-1:0]    last_q, pon_q;
  logic             taken_q;
  logic [PB-1:0]    pct_q;
  logic             oor_q, cal_q;

  // working registers
  logic [TB-1:0] now_q, tdiff_q;
  logic [SB-1:0] x_q, dmag_q, rem_q;
  logic [NB-1:0] quo_q;
  logic [CB-1:0] cnt_q;
  logic          nneg_q, dneg_q, dzero_q;

  logic                m_valid_q;
  logic [spcm_pkg::OUT_BITS-1:0] m_data_q;

  logic          in_acc, out_free;
  logic [TB-1:0] now_in;
  logic [AB-1:0] alu_a, alu_b, alu_diff;
  logic          alu_borrow;
  logic [SB:0]   rem_sh;
  logic          q_neg;

  assign now_in   = spcm_pkg::to_time(s_axis_tdata[spcm_pkg::NOW_BITS-1:0]);
  assign in_acc   = s_axis_tvalid & ctrl.in_ready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign rem_sh   = {rem_q, quo_q[NB-1]};
  assign q_neg    = nneg_q ^ dneg_q;

  assign stat.in_valid = s_axis_tvalid;
  assign stat.phase    = phase_q;
  assign stat.den_zero = dzero_q;
  assign stat.cnt_last = (cnt_q == CB'(NB - 1));
  assign stat.out_free = out_free;

  spcm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (ctrl.opnd)
      spcm_pkg::OPN_TIME: begin
        alu_a = AB'(now_q);
        alu_b = (phase_q == spcm_pkg::PH_OFF) ? AB'(last_q) : AB'(pon_q);
      end
      spcm_pkg::OPN_TCMP: begin
        alu_a = AB'(tdiff_q);
        alu_b = (phase_q == spcm_pkg::PH_OFF) ? AB'(interval_q) : AB'(warmup_q);
      end
      spcm_pkg::OPN_NSGN: begin
        alu_a = AB'(x_q);
        alu_b = AB'(dry_q);
      end
      spcm_pkg::OPN_NMAG: begin
        alu_a = nneg_q ? AB'(dry_q) : AB'(x_q);
        alu_b = nneg_q ? AB'(x_q) : AB'(dry_q);
      end
      spcm_pkg::OPN_DSGN: begin
        alu_a = AB'(wet_q);
        alu_b = AB'(dry_q);
      end
      spcm_pkg::OPN_DMAG: begin
        alu_a = dneg_q ? AB'(dry_q) : AB'(wet_q);
        alu_b = dneg_q ? AB'(wet_q) : AB'(dry_q);
      end
      spcm_pkg::OPN_DIV: begin
        alu_a = AB'(rem_sh);
        alu_b = AB'(dmag_q);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  spcm_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= spcm_pkg::INTERVAL_RST;
      warmup_q   <= spcm_pkg::WARMUP_RST;
      dry_q      <= spcm_pkg::DRY_RST;
      wet_q      <= spcm_pkg::WET_RST;
    end else if (cfg_we_i) begin
      unique case (spcm_pkg::cfg_reg_e'(cfg_addr_i))
        spcm_pkg::REG_INTERVAL: interval_q <= cfg_wdata_i;
        spcm_pkg::REG_WARMUP:   warmup_q   <= cfg_wdata_i;
        spcm_pkg::REG_DRY:      dry_q      <= SB'(cfg_wdata_i);
        spcm_pkg::REG_WET:      wet_q      <= SB'(cfg_wdata_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= spcm_pkg::PH_OFF;
      started_q <= 1'b0;
      last_q    <= '0;
      pon_q     <= '0;
      taken_q   <= 1'b0;
      pct_q     <= '0;
      oor_q     <= 1'b0;
      cal_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (in_acc) begin
        taken_q <= 1'b0;
        if (!started_q) begin
          started_q <= 1'b1;
          last_q    <= now_in;
          pon_q     <= now_in;
        end
        if (phase_q == spcm_pkg::PH_TURNOFF) begin
          phase_q <= spcm_pkg::PH_OFF;
        end
      end
      if (ctrl.ld_tcmp && !alu_borrow) begin
        if (phase_q == spcm_pkg::PH_OFF) begin
          pon_q   <= now_q;
          phase_q <= spcm_pkg::PH_PREPARE;
        end else begin
          phase_q <= spcm_pkg::PH_MEASURE;
        end
      end
      if (ctrl.ld_dmag) begin
        cnt_q <= '0;
      end
      if (ctrl.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctrl.finish) begin
        taken_q <= 1'b1;
        last_q  <= now_q;
        phase_q <= spcm_pkg::PH_TURNOFF;
        priority if (dzero_q) begin
          pct_q <= '0;
          oor_q <= 1'b0;
          cal_q <= 1'b1;
        end else if (quo_q == '0) begin
          // truncation toward zero lands on zero without clamping
          pct_q <= '0;
          oor_q <= 1'b0;
          cal_q <= 1'b0;
        end else if (q_neg) begin
          pct_q <= '0;
          oor_q <= 1'b1;
          cal_q <= 1'b0;
        end else if (quo_q > spcm_pkg::NUM_FULL) begin
          pct_q <= spcm_pkg::PCT_FULL;
          oor_q <= 1'b1;
          cal_q <= 1'b0;
        end else begin
          pct_q <= quo_q[PB-1:0];
          oor_q <= 1'b0;
          cal_q <= 1'b0;
        end
      end
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q <= now_in;
      x_q   <= SB'(s_axis_tdata[spcm_pkg::NOW_BITS +: spcm_pkg::ADC_BITS]);
    end
    if (ctrl.ld_tdiff) begin
      tdiff_q <= alu_diff[TB-1:0];
    end
    if (ctrl.ld_nsgn) begin
      nneg_q <= alu_borrow;
    end
    if (ctrl.ld_nmag) begin
      quo_q <= NB'(alu_diff[SB-1:0]) * NB'(100);
    end
    if (ctrl.ld_dsgn) begin
      dneg_q  <= alu_borrow;
      dzero_q <= (alu_diff == '0);
    end
    if (ctrl.ld_dmag) begin
      dmag_q <= alu_diff[SB-1:0];
      rem_q  <= '0;
    end
    if (ctrl.div_step) begin
      rem_q <= alu_borrow ? rem_sh[SB-1:0] : alu_diff[SB-1:0];
      quo_q <= {quo_q[NB-2:0], ~alu_borrow};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.out_load && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load && out_free) begin
      m_data_q <= spcm_pkg::OUT_BITS'({cal_q, oor_q, pct_q, taken_q, phase_q,
                                       phase_q != spcm_pkg::PH_OFF});
    end
  end

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ hdl/spcm_alu.sv @@
// ----------------------------------------------------------------------------
// spcm_alu
// Shared subtractor: difference and borrow, used for time checks, sign and
// magnitude steps and every restoring-division step.
// ----------------------------------------------------------------------------
module spcm_alu (
  input  logic [spcm_pkg::ALU_BITS-1:0] a_i,
  input  logic [spcm_pkg::ALU_BITS-1:0] b_i,
  output logic [spcm_pkg::ALU_BITS-1:0] diff_o,
  output logic                          borrow_o
);

  logic [spcm_pkg::ALU_BITS:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[spcm_pkg::ALU_BITS-1:0];
  assign borrow_o = full[spcm_pkg::ALU_BITS];

endmodule

@@ hdl/spcm_seq.sv @@
// ----------------------------------------------------------------------------
// spcm_seq
// Sequencer: walks one poll through the subtractor steps and hands the
// finished word to the output register.
// ----------------------------------------------------------------------------
module spcm_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spcm_pkg::seq_stat_t   stat_i,
  output spcm_pkg::seq_ctrl_t   ctrl_o
);

  spcm_pkg::seq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spcm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spcm_pkg::ST_IDLE: begin
        if (stat_i.in_valid) begin
          unique case (stat_i.phase)
            spcm_pkg::PH_OFF,
            spcm_pkg::PH_PREPARE: state_d = spcm_pkg::ST_TDIFF;
            spcm_pkg::PH_MEASURE: state_d = spcm_pkg::ST_NSGN;
            spcm_pkg::PH_TURNOFF: state_d = spcm_pkg::ST_OUT;
          endcase
        end
      end
      spcm_pkg::ST_TDIFF: state_d = spcm_pkg::ST_TCMP;
      spcm_pkg::ST_TCMP:  state_d = spcm_pkg::ST_OUT;
      spcm_pkg::ST_NSGN:  state_d = spcm_pkg::ST_NMAG;
      spcm_pkg::ST_NMAG:  state_d = spcm_pkg::ST_DSGN;
      spcm_pkg::ST_DSGN:  state_d = spcm_pkg::ST_DMAG;
      spcm_pkg::ST_DMAG:  state_d = stat_i.den_zero ? spcm_pkg::ST_FIN : spcm_pkg::ST_DIV;
      spcm_pkg::ST_DIV:   state_d = stat_i.cnt_last ? spcm_pkg::ST_FIN : spcm_pkg::ST_DIV;
      spcm_pkg::ST_FIN:   state_d = spcm_pkg::ST_OUT;
      spcm_pkg::ST_OUT:   state_d = stat_i.out_free ? spcm_pkg::ST_IDLE : spcm_pkg::ST_OUT;
      default:            state_d = spcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    ctrl_o.opnd = spcm_pkg::OPN_TIME;
    unique case (state_q)
      spcm_pkg::ST_IDLE:  ctrl_o.in_ready = 1'b1;
      spcm_pkg::ST_TDIFF: begin
        ctrl_o.opnd     = spcm_pkg::OPN_TIME;
        ctrl_o.ld_tdiff = 1'b1;
      end
      spcm_pkg::ST_TCMP: begin
        ctrl_o.opnd    = spcm_pkg::OPN_TCMP;
        ctrl_o.ld_tcmp = 1'b1;
      end
      spcm_pkg::ST_NSGN: begin
        ctrl_o.opnd    = spcm_pkg::OPN_NSGN;
        ctrl_o.ld_nsgn = 1'b1;
      end
      spcm_pkg::ST_NMAG: begin
        ctrl_o.opnd    = spcm_pkg::OPN_NMAG;
        ctrl_o.ld_nmag = 1'b1;
      end
      spcm_pkg::ST_DSGN: begin
        ctrl_o.opnd    = spcm_pkg::OPN_DSGN;
        ctrl_o.ld_dsgn = 1'b1;
      end
      spcm_pkg::ST_DMAG: begin
        ctrl_o.opnd    = spcm_pkg::OPN_DMAG;
        ctrl_o.ld_dmag = 1'b1;
      end
      spcm_pkg::ST_DIV: begin
        ctrl_o.opnd     = spcm_pkg::OPN_DIV;
        ctrl_o.div_step = 1'b1;
      end
      spcm_pkg::ST_FIN:   ctrl_o.finish   = 1'b1;
      spcm_pkg::ST_OUT:   ctrl_o.out_load = 1'b1;
      default:            ctrl_o.in_ready = 1'b0;
    endcase
  end

endmodule

@@ hdl/spcm_chk.sv @@
// ----------------------------------------------------------------------------
// spcm_chk
// Port-level checks of the moisture sampler, bound to the top level.
// ----------------------------------------------------------------------------
module spcm_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [spcm_pkg::OUT_BITS-1:0]   m_axis_tdata
);

  // a new moisture value only comes with the TurnOff phase
  a_taken_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:1] == spcm_pkg::PH_TURNOFF)
    else $error("sample taken outside TurnOff phase");

  a_power_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[2:1] != spcm_pkg::PH_OFF))
    else $error("sensor power disagrees with phase");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:4] <= spcm_pkg::PCT_FULL)
    else $error("moisture percent above full scale");

  a_cal_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[10:4] == 7'd0 && !m_axis_tdata[11])
    else $error("calibration error with nonzero result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

endmodule

bind sensor_power_cycle_moisture_sampler spcm_chk u_spcm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
